FILE: rtl/fdscan_pkg.sv
// Shared types and constants for the FAT directory entry scanner.
package fdscan_pkg;

    localparam int unsigned MaxEntries = 65536;
    localparam int unsigned PosWidth   = 16;
    localparam int unsigned PosLimitInt =
        ((MaxEntries - 1) > 65535) ? 65535 : (MaxEntries - 1);
    localparam logic [PosWidth-1:0] PosLimit = PosWidth'(PosLimitInt);

    // verdict codes
    localparam logic [3:0] VerdictGoing    = 4'd0;
    localparam logic [3:0] VerdictFound    = 4'd1;
    localparam logic [3:0] VerdictNotFound = 4'd2;
    localparam logic [3:0] VerdictFree     = 4'd3;
    localparam logic [3:0] VerdictNotEmpty = 4'd4;
    localparam logic [3:0] VerdictEmpty    = 4'd5;
    localparam logic [3:0] VerdictListed   = 4'd6;
    localparam logic [3:0] VerdictExtend   = 4'd7;
    localparam logic [3:0] VerdictIgnored  = 4'd8;

    // scan modes
    localparam logic [1:0] ModeFind  = 2'd0;
    localparam logic [1:0] ModeFree  = 2'd1;
    localparam logic [1:0] ModeEmpty = 2'd2;
    localparam logic [1:0] ModeList  = 2'd3;

    // config register indexes
    localparam logic [1:0] CfgScanMode   = 2'd0;
    localparam logic [1:0] CfgTargetName = 2'd1;
    localparam logic [1:0] CfgTargetExt  = 2'd2;

    // status byte and attribute codes
    localparam logic [7:0] StatusEnd     = 8'h00;
    localparam logic [7:0] StatusDeleted = 8'hE5;
    localparam logic [7:0] StatusDot     = 8'h2E;
    localparam logic [3:0] AttrLongName  = 4'hF;
    localparam int unsigned AttrDirBit   = 4;

    localparam logic [63:0] NameReset = 64'h2020202020202020;
    localparam logic [23:0] ExtReset  = 24'h202020;

    typedef struct packed {
        logic        restart;
        logic [63:0] name_bytes;
        logic [23:0] ext_bytes;
        logic [7:0]  attribute_bits;
        logic [15:0] cluster_high;
        logic [15:0] cluster_low;
        logic [31:0] entry_size;
        logic        last_in_chain;
    } entry_t;

    typedef struct packed {
        logic [3:0]          verdict;
        logic [PosWidth-1:0] entry_position;
        logic [31:0]         first_cluster;
        logic [31:0]         found_size;
        logic                is_directory;
    } result_t;

    typedef struct packed {
        logic [PosWidth-1:0] position;
        logic                finished;
    } scan_state_t;

    typedef struct packed {
        logic [1:0]  scan_mode;
        logic [63:0] target_name;
        logic [23:0] target_ext;
    } scan_cfg_t;

endpackage

FILE: rtl/fdscan_entry_if.sv
// Handshake channel carrying one directory entry word.
interface fdscan_entry_if;
    logic                  valid;
    logic                  ready;
    fdscan_pkg::entry_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/fdscan_result_if.sv
// Handshake channel carrying one scan result word.
interface fdscan_result_if;
    logic                  valid;
    logic                  ready;
    fdscan_pkg::result_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/fdscan_classify.sv
// Per-entry classification and scan state update (combinational).
module fdscan_classify (
    input  fdscan_pkg::entry_t      entry,
    input  fdscan_pkg::scan_cfg_t   cfg,
    input  fdscan_pkg::scan_state_t state_cur,
    output fdscan_pkg::result_t     result,
    output fdscan_pkg::scan_state_t state_next
);
    import fdscan_pkg::*;

    scan_state_t         eff;
    logic [7:0]          status;
    logic                is_end;
    logic                is_del;
    logic                is_dot;
    logic                is_lfn;
    logic                name_match;
    logic                last;
    logic [3:0]          verdict;
    logic                terminal;
    logic                keep_fields;

    assign eff.position = entry.restart ? '0   : state_cur.position;
    assign eff.finished = entry.restart ? 1'b0 : state_cur.finished;

    assign status     = entry.name_bytes[7:0];
    assign is_end     = (status == StatusEnd);
    assign is_del     = (status == StatusDeleted);
    assign is_dot     = (status == StatusDot);
    assign is_lfn     = (entry.attribute_bits[3:0] == AttrLongName);
    assign name_match = (entry.name_bytes == cfg.target_name) &&
                        (entry.ext_bytes == cfg.target_ext);
    assign last       = entry.last_in_chain;

    always_comb
    begin
        verdict = VerdictGoing;
        unique case (cfg.scan_mode)
            ModeFind:
            begin
                if (is_end)
                    verdict = VerdictNotFound;
                else if (!is_del && name_match)
                    verdict = VerdictFound;
                else
                    verdict = last ? VerdictNotFound : VerdictGoing;
            end
            ModeFree:
            begin
                if (is_end || is_del)
                    verdict = VerdictFree;
                else
                    verdict = last ? VerdictExtend : VerdictGoing;
            end
            ModeEmpty:
            begin
                if (is_end)
                    verdict = VerdictEmpty;
                else if (is_del || is_dot)
                    verdict = last ? VerdictEmpty : VerdictGoing;
                else
                    verdict = VerdictNotEmpty;
            end
            ModeList:
            begin
                if (is_end)
                    verdict = VerdictNotFound;
                else if (is_del || is_lfn)
                    verdict = last ? VerdictNotFound : VerdictGoing;
                else
                    verdict = VerdictListed;
            end
            default:
                verdict = VerdictGoing;
        endcase
    end

    assign terminal = ((verdict != VerdictGoing) && (verdict != VerdictListed)) || last;
    assign keep_fields = !eff.finished &&
                         ((verdict == VerdictFound) || (verdict == VerdictListed));

    always_comb
    begin
        result.entry_position = eff.position;
        if (eff.finished)
        begin
            result.verdict      = VerdictIgnored;
            state_next          = eff;
        end
        else
        begin
            result.verdict      = verdict;
            state_next.position = (eff.position < PosLimit) ?
                                  eff.position + 1'b1 : eff.position;
            state_next.finished = terminal;
        end
        if (keep_fields)
        begin
            result.first_cluster = {entry.cluster_high, entry.cluster_low};
            result.found_size    = entry.entry_size;
            result.is_directory  = entry.attribute_bits[AttrDirBit];
        end
        else
        begin
            result.first_cluster = '0;
            result.found_size    = '0;
            result.is_directory  = 1'b0;
        end
    end

endmodule

FILE: rtl/fat_directory_entry_scanner.sv
// Top level of the FAT directory entry scanner: registers, handshake, config.
//
//  channel  dir  word                               handshake
//  -------  ---  ---------------------------------  ------------------
//  entry    in   entry_t (restart .. last_in_chain) valid / ready
//  result   out  result_t (verdict .. is_directory) valid / ready
//  cfg      in   cfg_index (2b), cfg_data (64b)     cfg_we, no wait
//
//  One word in, one result out, one per cycle sustained while result.ready
//  is high. The path runs through the entry register, then classify plus
//  scan state update into the result register. Scan state advances only
//  when a word moves into the result register. rst_n clears both valids,
//  the scan state and the config registers to their defaults. A stall on
//  result backs up into entry.ready in the same cycle; nothing is dropped.
module fat_directory_entry_scanner (
    input  logic                   clk,
    input  logic                   rst_n,
    fdscan_entry_if.sink           entry,
    fdscan_result_if.source        result,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data
);
    import fdscan_pkg::*;

    // config registers
    scan_cfg_t   cfg_reg;

    // entry stage
    logic        in_vld_reg;
    entry_t      in_data_reg;

    // result stage
    logic        out_vld_reg;
    result_t     out_data_reg;

    // scan state
    scan_state_t state_reg;
    scan_state_t state_next;
    result_t     result_next;

    logic        advance;
    logic        take_in;

    // Entry stage drains when the result register is empty or being emptied.
    assign advance      = in_vld_reg && (!out_vld_reg || result.ready);
    assign entry.ready  = !in_vld_reg || advance;
    assign take_in      = entry.valid && entry.ready;

    assign result.valid   = out_vld_reg;
    assign result.payload = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_mode   <= ModeFind;
            cfg_reg.target_name <= NameReset;
            cfg_reg.target_ext  <= ExtReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgScanMode:   cfg_reg.scan_mode   <= cfg_data[1:0];
                CfgTargetName: cfg_reg.target_name <= cfg_data;
                CfgTargetExt:  cfg_reg.target_ext  <= cfg_data[23:0];
                default:       ;  // unused index: write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            if (take_in)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
            in_data_reg <= entry.payload;
        if (advance)
            out_data_reg <= result_next;
    end

    fdscan_classify u_classify (
        .entry      (in_data_reg),
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    // entry.ready may drop only while the entry stage holds a word
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !entry.ready |-> in_vld_reg)
        else $error("entry stalled with empty entry stage");

    // entry fields are zero unless the word was found or listed
    a_fields_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_data_reg.verdict != VerdictFound) &&
         (out_data_reg.verdict != VerdictListed)) |->
        ((out_data_reg.first_cluster == '0) && (out_data_reg.found_size == '0) &&
         !out_data_reg.is_directory))
        else $error("entry fields leaked on non-reporting verdict");

    // scan can only finish on a word moving to the result stage
    a_finish_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.finished) |-> $past(advance))
        else $error("scan finished without an advancing word");

    // a finished scan holds its position until restart
    a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.finished && !in_data_reg.restart) |=>
        (state_reg.position == $past(state_reg.position)))
        else $error("position moved after scan finished");

    // position counter saturates at its limit
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.position <= PosLimit)
        else $error("position beyond limit");

endmodule

FILE: tb/fdscan_tb_pkg.sv
// Scoreboard class for the directory entry scanner: verdict prediction and result checks.
`timescale 1ns / 100ps

package fdscan_tb_pkg;

    import fdscan_pkg::*;

    class verdict_board_t;
        logic [1:0]          mode;
        logic [63:0]         want_name;
        logic [23:0]         want_ext;
        logic [PosWidth-1:0] position;
        logic                finished;
        result_t             expected_verdicts[$];
        int                  mismatches;
        int                  checked;
        int                  live_words;

        function new();
            mode       = ModeFind;
            want_name  = NameReset;
            want_ext   = ExtReset;
            position   = '0;
            finished   = 1'b0;
            mismatches = 0;
            checked    = 0;
            live_words = 0;
        endfunction

        function void set_config(logic [1:0] idx, logic [63:0] val);
            case (idx)
                CfgScanMode:   mode = val[1:0];
                CfgTargetName: want_name = val;
                CfgTargetExt:  want_ext = val[23:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        // Verdict for one entry; advances the scan position and finished flag.
        function result_t classify_entry(entry_t e);
            result_t             r;
            logic [7:0]          status;
            logic [3:0]          v;
            logic [PosWidth-1:0] pos;
            r      = '0;
            status = e.name_bytes[7:0];
            if (e.restart) begin
                position = '0;
                finished = 1'b0;
            end
            if (finished) begin
                r.verdict        = VerdictIgnored;
                r.entry_position = position;
                return r;
            end
            pos = position;
            if (position < PosLimit)
                position = position + 1'b1;
            case (mode)
                ModeFind: begin
                    if (status == StatusEnd)
                        v = VerdictNotFound;
                    else if (status == StatusDeleted)
                        v = e.last_in_chain ? VerdictNotFound : VerdictGoing;
                    else if (e.name_bytes == want_name && e.ext_bytes == want_ext)
                        v = VerdictFound;
                    else
                        v = e.last_in_chain ? VerdictNotFound : VerdictGoing;
                end
                ModeFree: begin
                    if (status == StatusEnd || status == StatusDeleted)
                        v = VerdictFree;
                    else
                        v = e.last_in_chain ? VerdictExtend : VerdictGoing;
                end
                ModeEmpty: begin
                    if (status == StatusEnd)
                        v = VerdictEmpty;
                    else if (status == StatusDeleted || status == StatusDot)
                        v = e.last_in_chain ? VerdictEmpty : VerdictGoing;
                    else
                        v = VerdictNotEmpty;
                end
                default: begin
                    if (status == StatusEnd)
                        v = VerdictNotFound;
                    else if (status == StatusDeleted || e.attribute_bits[3:0] == AttrLongName)
                        v = e.last_in_chain ? VerdictNotFound : VerdictGoing;
                    else
                        v = VerdictListed;
                end
            endcase
            if (v != VerdictGoing && v != VerdictListed)
                finished = 1'b1;
            if (e.last_in_chain)
                finished = 1'b1;
            r.verdict        = v;
            r.entry_position = pos;
            if (v == VerdictFound || v == VerdictListed) begin
                r.first_cluster = {e.cluster_high, e.cluster_low};
                r.found_size    = e.entry_size;
                r.is_directory  = e.attribute_bits[AttrDirBit];
            end
            return r;
        endfunction

        function void note_entry(entry_t e);
            result_t r;
            r = classify_entry(e);
            if (r.verdict != VerdictIgnored)
                live_words++;
            expected_verdicts.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH at %0t: result word with nothing outstanding (v=%0d pos=%0d)",
                             $time, got.verdict, got.entry_position);
                return;
            end
            want = expected_verdicts.pop_front();
            if (want.verdict !== got.verdict || want.entry_position !== got.entry_position ||
                want.first_cluster !== got.first_cluster || want.found_size !== got.found_size ||
                want.is_directory !== got.is_directory) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"MISMATCH at %0t: expected v=%0d pos=%0d clu=%h size=%h dir=%b,",
                              " got v=%0d pos=%0d clu=%h size=%h dir=%b"}, $time,
                             want.verdict, want.entry_position, want.first_cluster,
                             want.found_size, want.is_directory,
                             got.verdict, got.entry_position, got.first_cluster,
                             got.found_size, got.is_directory);
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_fat_directory_entry_scanner.sv
// Testbench top for the FAT directory entry scanner: directed and random scans.
`timescale 1ns / 100ps

module tb_fat_directory_entry_scanner;

    import fdscan_pkg::*;
    import fdscan_tb_pkg::*;

    localparam int Latency     = 2;     // entry register + result register
    localparam int RandomWords = 1700;  // words sent in the random part
    localparam int HoldCycles  = 400;   // receiver back-pressure stretch
    localparam int IdleLimit   = 4000;  // cycles with no handshake before giving up

    localparam logic [63:0] NameA   = 64'h2020_2020_2020_2041;
    localparam logic [63:0] NameB   = 64'h2020_2020_2020_2042;
    localparam logic [63:0] NameDot = 64'h2020_2020_2020_202E;
    localparam logic [63:0] NameDd  = 64'h2020_2020_2020_2E2E;
    localparam logic [63:0] NameDel = 64'h2020_2020_2020_20E5;
    localparam logic [63:0] OnesDel = {56'hFF_FFFF_FFFF_FFFF, StatusDeleted};

    // stimulus classes for one directory slot
    typedef enum {
        KindLive, KindMatch, KindDeleted, KindEnd, KindDot, KindLongName, KindNoise
    } slot_kind_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    fdscan_entry_if  ent_ch ();
    fdscan_result_if res_ch ();

    fat_directory_entry_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .entry     (ent_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    verdict_board_t board;

    // current register contents, used to build matching names
    logic [1:0]  cur_mode;
    logic [63:0] cur_name;
    logic [23:0] cur_ext;

    bit calm;          // no gaps on either side while set
    bit hold_request;  // asks the result side for one long stall
    int sent_words;
    int phases;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------

    // mostly back-to-back, some short gaps, rare long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // status byte of an ordinary live slot
    function automatic logic [7:0] live_status();
        logic [7:0] s;
        do
            s = 8'($urandom_range(1, 255));
        while (s == StatusDeleted || s == StatusDot);
        return s;
    endfunction

    function automatic logic [63:0] pick_target();
        logic [63:0] t;
        int          r;
        r = $urandom_range(0, 9);
        if (r == 0) return '1;
        if (r == 1) return '0;
        if (r == 2) return {$urandom, $urandom};
        for (int b = 0; b < 8; b++)
            t[8*b +: 8] = ($urandom_range(0, 3) == 0) ? 8'h20 : 8'($urandom_range(65, 90));
        return t;
    endfunction

    function automatic logic [23:0] pick_ext();
        logic [23:0] t;
        int          r;
        r = $urandom_range(0, 9);
        if (r == 0) return '1;
        if (r == 1) return '0;
        for (int b = 0; b < 3; b++)
            t[8*b +: 8] = ($urandom_range(0, 2) == 0) ? 8'h20 : 8'($urandom_range(65, 90));
        return t;
    endfunction

    function automatic slot_kind_t pick_kind();
        slot_kind_t k;
        int         r;
        r = $urandom_range(0, 99);
        if      (r < 34) k = KindLive;
        else if (r < 44) k = KindMatch;
        else if (r < 58) k = KindDeleted;
        else if (r < 63) k = KindEnd;
        else if (r < 73) k = KindDot;
        else if (r < 90) k = KindLongName;
        else             k = KindNoise;
        // empty check dies on the first live slot, so lean on dot entries there
        if (cur_mode == ModeEmpty && k == KindLive && $urandom_range(0, 3) != 0)
            k = KindDot;
        return k;
    endfunction

    function automatic entry_t make_slot(slot_kind_t kind, bit first, bit last);
        entry_t e;
        e.restart        = first;
        e.name_bytes     = {$urandom, $urandom};
        e.ext_bytes      = 24'($urandom);
        e.attribute_bits = 8'($urandom);
        e.cluster_high   = 16'($urandom);
        e.cluster_low    = 16'($urandom);
        e.entry_size     = $urandom;
        e.last_in_chain  = last;
        case (kind)
            KindLive: begin
                e.name_bytes[7:0] = live_status();
                if (e.attribute_bits[3:0] == AttrLongName)
                    e.attribute_bits[0] = 1'b0;
            end
            KindMatch: begin
                e.name_bytes = cur_name;
                e.ext_bytes  = cur_ext;
            end
            KindDeleted: e.name_bytes[7:0] = StatusDeleted;
            KindEnd:     e.name_bytes[7:0] = StatusEnd;
            KindDot:     e.name_bytes[7:0] = StatusDot;
            KindLongName: begin
                e.name_bytes[7:0]      = live_status();
                e.attribute_bits[3:0]  = AttrLongName;
            end
            default: begin
                // noise: random restart and last flags break up the scan
                e.restart       = 1'($urandom);
                e.last_in_chain = 1'($urandom);
            end
        endcase
        return e;
    endfunction

    function automatic entry_t entry_of(bit rs, logic [63:0] nm, logic [23:0] ex,
                                        logic [7:0] at, logic [15:0] ch, logic [15:0] cl,
                                        logic [31:0] sz, bit lst);
        entry_t e;
        e.restart        = rs;
        e.name_bytes     = nm;
        e.ext_bytes      = ex;
        e.attribute_bits = at;
        e.cluster_high   = ch;
        e.cluster_low    = cl;
        e.entry_size     = sz;
        e.last_in_chain  = lst;
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Offer one word and hold it until taken. Valid is only dropped when a
    // gap follows, so back-to-back words never see a low/high in one step.
    task automatic send_entry(input entry_t e);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            ent_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ent_ch.valid   <= 1'b1;
        ent_ch.payload <= e;
        @(posedge clk);
        while (!ent_ch.ready) @(posedge clk);
        board.note_entry(e);
        sent_words++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_config(idx, val);
    endtask

    // Drain the block, then rewrite all three registers. Junk above the
    // field width checks that only the low bits land.
    task automatic apply_config(input logic [1:0] mode, input logic [63:0] name,
                                input logic [23:0] ext);
        logic [63:0] junk;
        ent_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (Latency + 2) @(posedge clk);
        junk      = {$urandom, $urandom};
        junk[1:0] = mode;
        write_reg(CfgScanMode, junk);
        write_reg(CfgTargetName, name);
        junk       = {$urandom, $urandom};
        junk[23:0] = ext;
        write_reg(CfgTargetExt, junk);
        cur_mode = mode;
        cur_name = name;
        cur_ext  = ext;
        phases++;
    endtask

    // One well-formed scan: restart on the first slot, maybe last on the final one.
    task automatic run_scan();
        int len;
        bit last_flag;
        len       = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        last_flag = ($urandom_range(0, 99) < 40);
        for (int i = 0; i < len; i++)
            send_entry(make_slot(pick_kind(), i == 0, last_flag && i == len - 1));
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls, one long hold on request, checking
    // ---------------------------------------------------------------
    initial begin : result_sink
        int stall;
        stall        = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                board.check_result(res_ch.payload);
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = HoldCycles;
            end
            if (stall > 0) begin
                stall--;
                res_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 15) begin
                stall        = pick_gap();
                res_ch.ready <= (stall == 0);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: any handshake on either side resets the idle count
    // ---------------------------------------------------------------
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IdleLimit) begin
            @(posedge clk);
            if ((ent_ch.valid && ent_ch.ready) || (res_ch.valid && res_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("Timed out after %0d cycles without a handshake", IdleLimit);
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        int base;
        int rnd_phase;
        logic [1:0] mode;

        board          = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        ent_ch.valid   = 1'b0;
        ent_ch.payload = '0;
        cur_mode       = ModeFind;
        cur_name       = NameReset;
        cur_ext        = ExtReset;
        calm           = 1'b0;
        hold_request   = 1'b0;
        sent_words     = 0;
        phases         = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // -- directed: find mode on reset targets (eight / three spaces) --
        send_entry(entry_of(1, NameA, ExtReset, 8'h20, 16'h1234, 16'h5678, 32'd100, 0));
        // all-ones fields, long-name attribute is an ordinary entry here
        send_entry(entry_of(0, NameReset, ExtReset, 8'hFF, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF, 0));
        // after a hit, further words are ignored and the position holds
        send_entry(entry_of(0, '1, '1, '1, '1, '1, '1, 1));
        // all-zero word: end marker
        send_entry(entry_of(1, '0, '0, '0, '0, '0, '0, 0));
        send_entry(entry_of(1, NameB, ExtReset, 8'h00, 16'h0001, 16'h0002, 32'd5, 1));
        send_entry(entry_of(1, NameDel, ExtReset, 8'h10, 16'h0003, 16'h0004, 32'd6, 1));

        // deleted slot whose bytes equal the target is still skipped
        apply_config(ModeFind, OnesDel, '1);
        send_entry(entry_of(1, OnesDel, '1, 8'h10, 16'h00AA, 16'h00BB, 32'd7, 0));
        send_entry(entry_of(0, '1, '1, 8'h01, 16'h00CC, 16'h00DD, 32'd8, 0));

        apply_config(ModeFind, '1, '1);
        send_entry(entry_of(1, '1, '1, 8'h0F, 16'hABCD, 16'h0001, 32'h1, 0));

        // -- free slot search --
        apply_config(ModeFree, NameA, ExtReset);
        send_entry(entry_of(1, NameA, ExtReset, 8'h20, 16'h0010, 16'h0020, 32'd9, 0));
        send_entry(entry_of(0, NameDel, ExtReset, 8'h20, 16'h0011, 16'h0021, 32'd10, 0));
        send_entry(entry_of(1, '0, ExtReset, 8'h00, 16'h0012, 16'h0022, 32'd11, 0));
        send_entry(entry_of(1, NameB, ExtReset, 8'h10, 16'h0013, 16'h0023, 32'd12, 1));

        // -- empty directory check --
        apply_config(ModeEmpty, '0, '0);
        send_entry(entry_of(1, NameDot, ExtReset, 8'h10, 16'h0000, 16'h0002, 32'd0, 0));
        send_entry(entry_of(0, NameDd, ExtReset, 8'h10, 16'h0000, 16'h0000, 32'd0, 0));
        send_entry(entry_of(0, NameDel, ExtReset, 8'h20, 16'h0001, 16'h0001, 32'd1, 0));
        send_entry(entry_of(0, '0, '0, 8'h00, 16'h0000, 16'h0000, 32'd0, 0));
        send_entry(entry_of(1, NameDot, ExtReset, 8'h10, 16'h0000, 16'h0002, 32'd0, 1));
        send_entry(entry_of(1, NameA, ExtReset, 8'h0F, 16'h0000, 16'h0000, 32'd0, 0));

        // -- listing --
        apply_config(ModeList, NameReset, ExtReset);
        send_entry(entry_of(1, NameA, ExtReset, 8'h10, 16'h8000, 16'h0001, 32'h8000_0000, 0));
        send_entry(entry_of(0, NameB, ExtReset, 8'h0F, 16'h0001, 16'h0002, 32'd3, 0));
        send_entry(entry_of(0, NameDel, ExtReset, 8'h20, 16'h0002, 16'h0003, 32'd4, 0));
        send_entry(entry_of(0, NameB, ExtReset, 8'h00, 16'h0003, 16'h0004, 32'd5, 1));
        send_entry(entry_of(0, NameA, ExtReset, 8'h20, 16'h0004, 16'h0005, 32'd6, 0));
        send_entry(entry_of(1, '0, ExtReset, 8'h20, 16'h0005, 16'h0006, 32'd7, 0));
        send_entry(entry_of(1, NameA, ExtReset, 8'h3F, 16'h0006, 16'h0007, 32'd8, 1));

        // -- random phases: fresh registers, a batch of scans each --
        base      = sent_words;
        rnd_phase = 0;
        while (sent_words - base < RandomWords) begin
            // walk through all four modes first, then pick freely
            mode = (rnd_phase < 4) ? 2'(rnd_phase) : 2'($urandom_range(0, 3));
            calm = (rnd_phase != 1) && ($urandom_range(0, 99) < 15);
            apply_config(mode, pick_target(), pick_ext());
            // fill the pipe against a stalled receiver once
            if (rnd_phase == 1)
                hold_request = 1'b1;
            repeat ($urandom_range(4, 14)) run_scan();
            rnd_phase++;
        end
        calm = 1'b0;

        ent_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (Latency + 4) @(posedge clk);

        $display("Ran %0d entry words (%0d not ignored) over %0d register settings,",
                 sent_words, board.live_words, phases);
        $display("all four scan modes, random gaps and one long receiver stall; %0d checked, %0d bad.",
                 board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
